// ----- sv/msicc_pkg.sv -----
// ----------------------------------------------------------------------------
// msicc_pkg
// Shared types, codes and default sizes for the MSI/E set-associative cache
// controller: line states, directory request codes, operation codes, the
// controller state encoding and the control/status bundles.
// ----------------------------------------------------------------------------
package msicc_pkg;

	// default geometry
	localparam int DEF_NUM_SETS   = 64;
	localparam int DEF_NUM_WAYS   = 4;
	localparam int DEF_LINE_BYTES = 64;
	localparam int DEF_ADDR_BITS  = 32;

	// fixed field widths
	localparam int ADDR_W    = 32;
	localparam int BLOCK_W   = 26;
	localparam int PID_W     = 4;
	localparam int APB_DW    = 32;
	localparam int PADDR_W   = 2;

	localparam logic [PADDR_W-1:0] REG_PROC_ID = 2'd0;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_INVAL = 2'd2,
		OP_INTV  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		LS_I = 2'd0,
		LS_S = 2'd1,
		LS_E = 2'd2,
		LS_M = 2'd3
	} line_st_t;

	typedef enum logic [1:0] {
		REQ_NONE    = 2'd0,
		REQ_READ    = 2'd1,
		REQ_READX   = 2'd2,
		REQ_UPGRADE = 2'd3
	} dir_req_t;

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_LOOKUP = 4'b0100,
		S_UPDATE = 4'b1000
	} ctrl_state_t;

	typedef struct packed {
		logic accept;     // latch request, read set rows
		logic clear_en;   // write one cleared row of line state and LRU ranks
		logic lookup_en;  // register tag compare and victim choice
		logic update_en;  // write back the set, register the result
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_status_t;

endpackage

// ----- sv/msicc_ram.sv -----
// ----------------------------------------------------------------------------
// msicc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msicc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/msicc_ctrl.sv -----
// ----------------------------------------------------------------------------
// msicc_ctrl
// Sequencer for the cache controller: clearing pass after reset, then
// accept -> lookup -> update for each request.
// ----------------------------------------------------------------------------
module msicc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output msicc_pkg::dp_cmd_t     cmd,
	input  msicc_pkg::dp_status_t  status
);

	msicc_pkg::ctrl_state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			msicc_pkg::S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_last) begin
					state_d = msicc_pkg::S_IDLE;
				end
			end
			msicc_pkg::S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = msicc_pkg::S_LOOKUP;
				end
			end
			msicc_pkg::S_LOOKUP: begin
				cmd.lookup_en = 1'b1;
				state_d       = msicc_pkg::S_UPDATE;
			end
			msicc_pkg::S_UPDATE: begin
				cmd.update_en = 1'b1;
				state_d       = msicc_pkg::S_IDLE;
			end
			default: begin
				state_d = msicc_pkg::S_CLEAR;
			end
		endcase
	end

	assign busy = (state_q != msicc_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msicc_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/msicc_dp.sv -----
// ----------------------------------------------------------------------------
// msicc_dp
// Datapath: address split, tag and line-state/LRU set RAMs, tag compare,
// victim choice, MSI/E next state, LRU rank update and result registers.
// ----------------------------------------------------------------------------
module msicc_dp #(
	parameter int NUM_SETS   = msicc_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS   = msicc_pkg::DEF_NUM_WAYS,
	parameter int LINE_BYTES = msicc_pkg::DEF_LINE_BYTES,
	parameter int ADDR_BITS  = msicc_pkg::DEF_ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  msicc_pkg::dp_cmd_t             cmd,
	output msicc_pkg::dp_status_t          status,
	input  logic [1:0]                     operation,
	input  logic [msicc_pkg::ADDR_W-1:0]   address,
	input  logic                           fill_exclusive,
	output logic                           done,
	output logic                           hit,
	output logic [1:0]                     dir_request,
	output logic                           evict_valid,
	output logic [msicc_pkg::BLOCK_W-1:0]  evict_block,
	output logic                           write_back,
	output logic [1:0]                     new_state
);

	localparam int AW      = msicc_pkg::ADDR_W;
	localparam int OFF_W   = $clog2(LINE_BYTES);
	localparam int SET_W   = $clog2(NUM_SETS);
	localparam int SET_IW  = (SET_W > 0) ? SET_W : 1;
	localparam int EFF_W   = (ADDR_BITS < AW) ? ADDR_BITS : AW;
	localparam int TAG_RAW = EFF_W - OFF_W - SET_W;
	localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int RANK_W  = WAY_W;
	localparam int META_W  = NUM_WAYS * (2 + RANK_W);
	localparam int TROW_W  = NUM_WAYS * TAG_W;
	localparam logic [AW-1:0] ADDR_MASK =
		(ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_WAYS - 1);

	// request registers
	logic [AW-1:0]     addr_eff;
	logic [SET_IW-1:0] in_set;
	logic [TAG_W-1:0]  in_tag;
	msicc_pkg::op_t    op_q;
	logic [SET_IW-1:0] set_q;
	logic [TAG_W-1:0]  tag_q;
	logic              fillx_q;

	assign addr_eff = address & ADDR_MASK;
	assign in_set   = (SET_W > 0) ? addr_eff[OFF_W +: SET_IW] : '0;
	assign in_tag   = TAG_W'(addr_eff >> (OFF_W + SET_W));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= msicc_pkg::op_t'(operation);
			set_q   <= in_set;
			tag_q   <= in_tag;
			fillx_q <= fill_exclusive;
		end
	end

	// clearing pass counter
	logic [SET_IW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_en) begin
			clr_cnt_q <= clr_cnt_q + SET_IW'(1);
		end
	end

	assign status.clear_last = (clr_cnt_q == SET_IW'(NUM_SETS - 1));

	// set RAMs: one row per set
	logic [NUM_WAYS-1:0][1:0]        st_rd, st_n;
	logic [NUM_WAYS-1:0][RANK_W-1:0] rk_rd, rk_n;
	logic [NUM_WAYS-1:0][TAG_W-1:0]  tags_rd, tags_n;
	logic [META_W-1:0]               meta_rd;
	logic                            fill_c;

	assign {rk_rd, st_rd} = meta_rd;

	msicc_ram #(
		.WIDTH (META_W),
		.DEPTH (NUM_SETS)
	) u_meta_ram (
		.clk   (clk),
		.we    (cmd.clear_en | cmd.update_en),
		.waddr (cmd.clear_en ? clr_cnt_q : set_q),
		.wdata (cmd.clear_en ? {META_W{1'b0}} : {rk_n, st_n}),
		.re    (cmd.accept),
		.raddr (in_set),
		.rdata (meta_rd)
	);

	msicc_ram #(
		.WIDTH (TROW_W),
		.DEPTH (NUM_SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (cmd.update_en & fill_c),
		.waddr (set_q),
		.wdata (tags_n),
		.re    (cmd.accept),
		.raddr (in_set),
		.rdata (tags_rd)
	);

	// lookup: tag compare and victim choice
	logic             hit_c;
	logic [WAY_W-1:0] hway_c, vic_c;
	logic [RANK_W-1:0] top_c;
	logic             hit_s1;
	logic [WAY_W-1:0] hway_s1, vic_s1;

	always_comb begin
		hit_c  = 1'b0;
		hway_c = '0;
		vic_c  = '0;
		top_c  = '0;
		// downward scan so the lowest matching way wins
		for (int v = NUM_WAYS - 1; v >= 0; v--) begin
			if (st_rd[v] != msicc_pkg::LS_I && tags_rd[v] == tag_q) begin
				hit_c  = 1'b1;
				hway_c = WAY_W'(v);
			end
		end
		// oldest rank, ties to the highest way
		for (int v = 0; v < NUM_WAYS; v++) begin
			if (rk_rd[v] >= top_c) begin
				top_c = rk_rd[v];
				vic_c = WAY_W'(v);
			end
		end
		// first invalid way overrides LRU
		for (int v = NUM_WAYS - 1; v >= 0; v--) begin
			if (st_rd[v] == msicc_pkg::LS_I) begin
				vic_c = WAY_W'(v);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup_en) begin
			hit_s1  <= hit_c;
			hway_s1 <= hway_c;
			vic_s1  <= vic_c;
		end
	end

	// update: next line state, LRU ranks, victim report
	logic                       proc_c;
	logic [WAY_W-1:0]           way_c;
	logic [1:0]                 old_st_c;
	logic [RANK_W-1:0]          old_rk_c;
	logic [1:0]                 req_c;
	logic                       ev_c;
	logic [msicc_pkg::BLOCK_W-1:0] evb_c;
	logic                       wb_c;
	logic [1:0]                 res_c;

	always_comb begin
		proc_c   = op_q inside {msicc_pkg::OP_READ, msicc_pkg::OP_WRITE};
		way_c    = hit_s1 ? hway_s1 : vic_s1;
		old_st_c = st_rd[way_c];
		old_rk_c = rk_rd[way_c];
		st_n     = st_rd;
		rk_n     = rk_rd;
		tags_n   = tags_rd;
		fill_c   = 1'b0;
		req_c    = msicc_pkg::REQ_NONE;
		ev_c     = 1'b0;
		evb_c    = '0;
		wb_c     = 1'b0;
		res_c    = msicc_pkg::LS_I;
		if (proc_c) begin
			for (int v = 0; v < NUM_WAYS; v++) begin
				if (WAY_W'(v) != way_c && rk_rd[v] <= old_rk_c && rk_rd[v] < RANK_MAX) begin
					rk_n[v] = rk_rd[v] + RANK_W'(1);
				end
			end
			rk_n[way_c] = '0;
			if (hit_s1) begin
				if (op_q == msicc_pkg::OP_WRITE) begin
					if (old_st_c == msicc_pkg::LS_S) begin
						req_c = msicc_pkg::REQ_UPGRADE;
					end
					st_n[way_c] = msicc_pkg::LS_M;
					res_c       = msicc_pkg::LS_M;
				end else begin
					res_c = old_st_c;
				end
			end else begin
				fill_c = 1'b1;
				if (op_q == msicc_pkg::OP_WRITE) begin
					req_c = msicc_pkg::REQ_READX;
					res_c = msicc_pkg::LS_M;
				end else begin
					req_c = msicc_pkg::REQ_READ;
					res_c = fillx_q ? msicc_pkg::LS_E : msicc_pkg::LS_S;
				end
				if (old_st_c != msicc_pkg::LS_I) begin
					ev_c  = 1'b1;
					evb_c = msicc_pkg::BLOCK_W'((64'(tags_rd[way_c]) << SET_W) | 64'(set_q));
					wb_c  = (old_st_c == msicc_pkg::LS_M);
				end
				tags_n[way_c] = tag_q;
				st_n[way_c]   = res_c;
			end
		end else if (hit_s1) begin
			res_c       = (op_q == msicc_pkg::OP_INVAL) ? msicc_pkg::LS_I : msicc_pkg::LS_S;
			st_n[way_c] = res_c;
		end
	end

	// result registers
	logic                          done_q;
	logic                          hit_q;
	logic [1:0]                    req_q;
	logic                          ev_q;
	logic [msicc_pkg::BLOCK_W-1:0] evb_q;
	logic                          wb_q;
	logic [1:0]                    res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update_en) begin
			hit_q <= hit_s1;
			req_q <= req_c;
			ev_q  <= ev_c;
			evb_q <= evb_c;
			wb_q  <= wb_c;
			res_q <= res_c;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign dir_request = req_q;
	assign evict_valid = ev_q;
	assign evict_block = evb_q;
	assign write_back  = wb_q;
	assign new_state   = res_q;

endmodule

// ----- sv/msicc_set_assoc_cache_controller.sv -----
// ----------------------------------------------------------------------------
// msi_set_assoc_cache_controller
// Tag/state side of a set-associative cache with true-LRU replacement and
// MSI/E directory coherence, with an APB register for the processor id.
//
//   channel   signals                                   handshake
//   request   operation, address, fill_exclusive        start & !busy
//   result    hit, dir_request, evict_valid,             done (one cycle)
//             evict_block, write_back, new_state
//   config    psel, penable, pwrite, paddr, pwdata,      psel & penable
//             prdata, pready
//
// A request runs through set RAM read, tag compare / victim choice, then
// set write-back; done pulses in the cycle after the write-back, and a new
// request may be accepted in that same cycle. The read, compare and
// write-back of the set row run in turn, so a new request is not taken
// before the last one is through.
// After reset a clearing pass writes every set row (NUM_SETS rows, 64 by
// default), with busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module msi_set_assoc_cache_controller #(
	parameter int NUM_SETS   = msicc_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS   = msicc_pkg::DEF_NUM_WAYS,
	parameter int LINE_BYTES = msicc_pkg::DEF_LINE_BYTES,
	parameter int ADDR_BITS  = msicc_pkg::DEF_ADDR_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      operation,
	input  logic [msicc_pkg::ADDR_W-1:0]    address,
	input  logic                            fill_exclusive,
	output logic                            done,
	output logic                            hit,
	output logic [1:0]                      dir_request,
	output logic                            evict_valid,
	output logic [msicc_pkg::BLOCK_W-1:0]   evict_block,
	output logic                            write_back,
	output logic [1:0]                      new_state,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [msicc_pkg::PADDR_W-1:0]   paddr,
	input  logic [msicc_pkg::APB_DW-1:0]    pwdata,
	output logic [msicc_pkg::APB_DW-1:0]    prdata,
	output logic                            pready
);

	msicc_pkg::dp_cmd_t    cmd;
	msicc_pkg::dp_status_t status;

	// processor id register (read back over APB)
	logic [msicc_pkg::PID_W-1:0] pid_q;
	logic                        reg_sel;

	assign reg_sel = (paddr == msicc_pkg::REG_PROC_ID);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? msicc_pkg::APB_DW'(pid_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			pid_q <= pwdata[msicc_pkg::PID_W-1:0];
		end
	end

	msicc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	msicc_dp #(
		.NUM_SETS   (NUM_SETS),
		.NUM_WAYS   (NUM_WAYS),
		.LINE_BYTES (LINE_BYTES),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (operation),
		.address        (address),
		.fill_exclusive (fill_exclusive),
		.done           (done),
		.hit            (hit),
		.dir_request    (dir_request),
		.evict_valid    (evict_valid),
		.evict_block    (evict_block),
		.write_back     (write_back),
		.new_state      (new_state)
	);

endmodule
